@@ rtl/asfp_pkg.sv @@
// Shared types, format codes and helper functions of the sample format packer.
package asfp_pkg;

	localparam int FMT_W        = 5;
	localparam int CHANNELS_DEF = 2;

	typedef enum logic [FMT_W-1:0] {
		FMT_I16_MSB      = 5'd0,
		FMT_I24_MSB      = 5'd1,
		FMT_I32_MSB      = 5'd2,
		FMT_F32_MSB      = 5'd3,
		FMT_F64_MSB      = 5'd4,
		FMT_I32_MSB16    = 5'd5,
		FMT_I32_MSB18    = 5'd6,
		FMT_I32_MSB20    = 5'd7,
		FMT_I32_MSB24    = 5'd8,
		FMT_I16_LSB      = 5'd9,
		FMT_I24_LSB      = 5'd10,
		FMT_I32_LSB      = 5'd11,
		FMT_F32_LSB      = 5'd12,
		FMT_F64_LSB      = 5'd13,
		FMT_I32_LSB16    = 5'd14,
		FMT_I32_LSB18    = 5'd15,
		FMT_I32_LSB20    = 5'd16,
		FMT_I32_LSB24    = 5'd17,
		FMT_UNSUPPORTED  = 5'd18
	} fmt_t;

	localparam logic [FMT_W-1:0] FMT_RESET = FMT_F32_LSB;

	typedef enum logic [2:0] {
		SC16, SC18, SC20, SC24, SC32
	} scale_t;

	typedef struct packed {
		logic        channel;
		logic [31:0] sample_bits;
		logic        last_of_frame;
	} in_t;

	typedef struct packed {
		logic [63:0] packed_word;
		logic [3:0]  byte_count;
		logic        end_of_frame;
	} out_t;

	function automatic scale_t fmt_scale(input fmt_t f);
		scale_t s;
		case (f)
			FMT_I16_MSB, FMT_I32_MSB16, FMT_I16_LSB, FMT_I32_LSB16: s = SC16;
			FMT_I32_MSB18, FMT_I32_LSB18:                          s = SC18;
			FMT_I32_MSB20, FMT_I32_LSB20:                          s = SC20;
			FMT_I24_MSB, FMT_I32_MSB24, FMT_I24_LSB, FMT_I32_LSB24: s = SC24;
			default:                                               s = SC32;
		endcase
		return s;
	endfunction

	// Full scale as a normalised 24-bit significand
	function automatic logic [23:0] scale_mant(input scale_t s);
		logic [23:0] r;
		case (s)
			SC16:    r = 24'hFFFE00;
			SC18:    r = 24'hFFFF80;
			SC20:    r = 24'hFFFFE0;
			SC24:    r = 24'hFFFFFE;
			default: r = 24'h800000;
		endcase
		return r;
	endfunction

	// 150 minus the binary exponent of the full-scale significand
	function automatic logic [7:0] scale_base(input scale_t s);
		logic [7:0] r;
		case (s)
			SC16:    r = 8'd159;
			SC18:    r = 8'd157;
			SC20:    r = 8'd155;
			SC24:    r = 8'd151;
			default: r = 8'd142;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] bswap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [31:0] bswap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [63:0] bswap64(input logic [63:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24],
			v[39:32], v[47:40], v[55:48], v[63:56]};
	endfunction

endpackage

@@ rtl/asfp_scaler.sv @@
// Three-stage float to integer scaler: clamp and multiply, round, shift and saturate.
module asfp_scaler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         bits,
	input  asfp_pkg::scale_t    scale,
	output logic [31:0]         value
);
	import asfp_pkg::*;

	logic              sgn_c;
	logic [7:0]        e_c;
	logic [22:0]       m_c;
	logic              nan_c;
	logic              big_c;
	logic              zero_c;
	logic [23:0]       mant_c;
	logic [7:0]        ex_c;
	logic [47:0]       prod_c;

	logic [47:0]       prod_s2;
	logic [7:0]        ex_s2;
	logic              sgn_s2;
	logic              zero_s2;
	scale_t            scale_s2;

	logic              lead_c;
	logic [23:0]       mt_c;
	logic              guard_c;
	logic              sticky_c;
	logic [24:0]       r_c;
	logic signed [9:0] sh_c;

	logic [24:0]       r_s3;
	logic signed [9:0] sh_s3;
	logic              sgn_s3;
	logic              zero_s3;

	logic [32:0]       mag_c;
	logic [9:0]        lsh_c;
	logic [31:0]       val_c;

	// clamp to [-1,1]; NaN, zero and subnormals give zero
	always_comb begin
		sgn_c  = bits[31];
		e_c    = bits[30:23];
		m_c    = bits[22:0];
		nan_c  = (e_c == 8'hFF) && (m_c != 23'd0);
		big_c  = (e_c > 8'd127) || ((e_c == 8'd127) && (m_c != 23'd0));
		zero_c = nan_c || (e_c == 8'd0);
		if (big_c) begin
			mant_c = 24'h800000;
			ex_c   = 8'd127;
		end else begin
			mant_c = {1'b1, m_c};
			ex_c   = e_c;
		end
		prod_c = {24'b0, mant_c} * {24'b0, scale_mant(scale)};
	end

	always_ff @(posedge clk) begin
		prod_s2  <= prod_c;
		ex_s2    <= ex_c;
		sgn_s2   <= sgn_c;
		zero_s2  <= zero_c;
		scale_s2 <= scale;
	end

	// round the product to 24 significant bits, nearest even
	always_comb begin
		lead_c   = prod_s2[47];
		mt_c     = lead_c ? prod_s2[47:24] : prod_s2[46:23];
		guard_c  = lead_c ? prod_s2[23] : prod_s2[22];
		sticky_c = lead_c ? (|prod_s2[22:0]) : (|prod_s2[21:0]);
		r_c      = {1'b0, mt_c} + {24'b0, guard_c & (sticky_c | mt_c[0])};
		sh_c     = $signed({2'b0, scale_base(scale_s2)}) - $signed({2'b0, ex_s2})
			- (lead_c ? 10'sd24 : 10'sd23);
	end

	always_ff @(posedge clk) begin
		r_s3    <= r_c;
		sh_s3   <= sh_c;
		sgn_s3  <= sgn_s2;
		zero_s3 <= zero_s2;
	end

	// truncate toward zero, then apply the sign; positive full scale saturates
	always_comb begin
		lsh_c = 10'(-sh_s3);
		if (zero_s3) begin
			mag_c = 33'd0;
		end else if (sh_s3 > 10'sd0) begin
			if (sh_s3 >= 10'sd25) begin
				mag_c = 33'd0;
			end else begin
				mag_c = {8'b0, r_s3} >> sh_s3[4:0];
			end
		end else begin
			mag_c = {8'b0, r_s3} << lsh_c[3:0];
		end
		if (sgn_s3) begin
			val_c = 32'd0 - mag_c[31:0];
		end else if (mag_c[32] || mag_c[31]) begin
			val_c = 32'h7FFFFFFF;
		end else begin
			val_c = mag_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value <= 32'd0;
		end else begin
			value <= val_c;
		end
	end

endmodule

@@ rtl/audio_sample_format_packer_core.sv @@
// Top level of the sample format packer: format registers, pipeline and byte packing.
//
//  port group      dir  transfer when         payload
//  start/busy      in   start && !busy        sample_in (channel, sample_bits, last_of_frame)
//  done            out  every cycle done=1    result (packed_word, byte_count, end_of_frame)
//  cfg_we          in   cfg_we                cfg_index, cfg_data (format of one channel)
//
// One sample per clock; busy stays low. An accepted sample shows on result with
// done high once it has passed the whole pipeline. The depth is set by the scaler:
// one stage for the clamp and 24x24 multiply, one for rounding, one for the
// truncating shift, plus the input and output registers.
// Reset clears the valid bits and sets every channel to little-endian float32.
// The receiver cannot stall, so the pipeline advances every cycle.
module audio_sample_format_packer_core #(
	parameter int CHANNELS = asfp_pkg::CHANNELS_DEF,
	parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  asfp_pkg::in_t               sample_in,
	output logic                        done,
	output asfp_pkg::out_t              result,
	input  logic                        cfg_we,
	input  logic [IDX_W-1:0]            cfg_index,
	input  logic [asfp_pkg::FMT_W-1:0]  cfg_data
);
	import asfp_pkg::*;

	logic [FMT_W-1:0] fmt_q [CHANNELS];

	fmt_t             fmt_c;
	logic             take_c;

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	fmt_t             fmt_s1, fmt_s2, fmt_s3, fmt_s4;
	logic [31:0]      bits_s1, bits_s2, bits_s3, bits_s4;
	logic             eof_s1, eof_s2, eof_s3, eof_s4;
	logic [4:0]       k_c;
	logic [4:0]       k_s2;
	logic [63:0]      dbl_c;
	logic [63:0]      dbl_s3, dbl_s4;
	logic [31:0]      v_s4;
	logic [22:0]      mn_c;

	logic             done_q;
	out_t             result_q;
	out_t             pack_c;

	assign busy   = 1'b0;
	assign take_c = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// format registers, one per channel; writes beyond the channels drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				fmt_q[i] <= FMT_RESET;
			end
		end else if (cfg_we && (int'(cfg_index) < CHANNELS)) begin
			fmt_q[cfg_index] <= cfg_data;
		end
	end

	// pick the channel's format; unknown codes and absent channels are unsupported
	always_comb begin
		fmt_c = FMT_UNSUPPORTED;
		if (int'(sample_in.channel) < CHANNELS) begin
			if (fmt_q[IDX_W'(sample_in.channel)] < FMT_UNSUPPORTED) begin
				fmt_c = fmt_t'(fmt_q[IDX_W'(sample_in.channel)]);
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= take_c;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		fmt_s1  <= fmt_c;
		bits_s1 <= sample_in.sample_bits;
		eof_s1  <= sample_in.last_of_frame;
		fmt_s2  <= fmt_s1;
		bits_s2 <= bits_s1;
		eof_s2  <= eof_s1;
		fmt_s3  <= fmt_s2;
		bits_s3 <= bits_s2;
		eof_s3  <= eof_s2;
		fmt_s4  <= fmt_s3;
		bits_s4 <= bits_s3;
		eof_s4  <= eof_s3;
	end

	asfp_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.bits   (bits_s1),
		.scale  (fmt_scale(fmt_s1)),
		.value  (v_s4)
	);

	// widening to double: count the shift that normalises a subnormal
	always_comb begin
		k_c = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (bits_s1[i]) begin
				k_c = 5'(23 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s2 <= k_c;
	end

	always_comb begin
		mn_c = bits_s2[22:0] << k_s2;
		if (bits_s2[30:23] == 8'hFF) begin
			dbl_c = {bits_s2[31], 11'h7FF,
				bits_s2[22:0] | ((bits_s2[22:0] != 23'd0) ? 23'h400000 : 23'd0), 29'b0};
		end else if (bits_s2[30:23] == 8'd0) begin
			if (bits_s2[22:0] == 23'd0) begin
				dbl_c = {bits_s2[31], 63'b0};
			end else begin
				dbl_c = {bits_s2[31], 11'd897 - {6'b0, k_s2}, mn_c, 29'b0};
			end
		end else begin
			dbl_c = {bits_s2[31], {3'b0, bits_s2[30:23]} + 11'd896, bits_s2[22:0], 29'b0};
		end
	end

	always_ff @(posedge clk) begin
		dbl_s3 <= dbl_c;
		dbl_s4 <= dbl_s3;
	end

	// lay the bytes out in memory order, first byte in the low bits
	always_comb begin
		pack_c.end_of_frame = eof_s4;
		case (fmt_s4)
			FMT_I16_MSB: begin
				pack_c.packed_word = {48'b0, bswap16(v_s4[15:0])};
				pack_c.byte_count  = 4'd2;
			end
			FMT_I24_MSB: begin
				pack_c.packed_word = {40'b0, v_s4[7:0], v_s4[15:8], v_s4[23:16]};
				pack_c.byte_count  = 4'd3;
			end
			FMT_I32_MSB: begin
				pack_c.packed_word = {32'b0, bswap32(v_s4)};
				pack_c.byte_count  = 4'd4;
			end
			FMT_F32_MSB: begin
				pack_c.packed_word = {32'b0, bswap32(bits_s4)};
				pack_c.byte_count  = 4'd4;
			end
			FMT_F64_MSB: begin
				pack_c.packed_word = bswap64(dbl_s4);
				pack_c.byte_count  = 4'd8;
			end
			FMT_I32_MSB16: begin
				pack_c.packed_word = {32'b0, bswap32({v_s4[15:0], 16'b0})};
				pack_c.byte_count  = 4'd4;
			end
			FMT_I32_MSB18: begin
				pack_c.packed_word = {32'b0, bswap32({v_s4[17:0], 14'b0})};
				pack_c.byte_count  = 4'd4;
			end
			FMT_I32_MSB20: begin
				pack_c.packed_word = {32'b0, bswap32({v_s4[19:0], 12'b0})};
				pack_c.byte_count  = 4'd4;
			end
			FMT_I32_MSB24: begin
				pack_c.packed_word = {32'b0, bswap32({v_s4[23:0], 8'b0})};
				pack_c.byte_count  = 4'd4;
			end
			FMT_I16_LSB: begin
				pack_c.packed_word = {48'b0, v_s4[15:0]};
				pack_c.byte_count  = 4'd2;
			end
			FMT_I24_LSB: begin
				pack_c.packed_word = {40'b0, v_s4[23:0]};
				pack_c.byte_count  = 4'd3;
			end
			FMT_I32_LSB: begin
				pack_c.packed_word = {32'b0, v_s4};
				pack_c.byte_count  = 4'd4;
			end
			FMT_F32_LSB: begin
				pack_c.packed_word = {32'b0, bits_s4};
				pack_c.byte_count  = 4'd4;
			end
			FMT_F64_LSB: begin
				pack_c.packed_word = dbl_s4;
				pack_c.byte_count  = 4'd8;
			end
			FMT_I32_LSB16: begin
				pack_c.packed_word = {48'b0, v_s4[15:0]};
				pack_c.byte_count  = 4'd4;
			end
			FMT_I32_LSB18: begin
				pack_c.packed_word = {46'b0, v_s4[17:0]};
				pack_c.byte_count  = 4'd4;
			end
			FMT_I32_LSB20: begin
				pack_c.packed_word = {44'b0, v_s4[19:0]};
				pack_c.byte_count  = 4'd4;
			end
			FMT_I32_LSB24: begin
				pack_c.packed_word = {40'b0, v_s4[23:0]};
				pack_c.byte_count  = 4'd4;
			end
			default: begin
				pack_c.packed_word = 64'd0;
				pack_c.byte_count  = 4'd0;
			end
		endcase
	end

	// register the finished result
	always_ff @(posedge clk) begin
		result_q <= pack_c;
	end

	// every transfer in yields exactly one result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted sample produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##5 !done)
		else $error("result without an accepted sample");

	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.byte_count == 4'd0)) |-> (result.packed_word == 64'd0))
		else $error("unsupported format carries data");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.byte_count == 4'd0) || (result.byte_count == 4'd2) ||
			(result.byte_count == 4'd3) || (result.byte_count == 4'd4) ||
			(result.byte_count == 4'd8)))
		else $error("illegal byte count");

endmodule
